[rtl/sha256_stream_hasher_unit_macros.svh]
// Assertion macros shared by the hasher modules.
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SHS_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

[rtl/shs_pkg.sv]
// Package with SHA-256 constants, functions and shared types for the hasher.
package shs_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  typedef logic [31:0] word_t;

  // One block job handed from the packer to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         fin;    // last block of the message: emit digest afterwards
  } job_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_ADD,
    ENG_OUT
  } eng_state_e;

  typedef enum logic [1:0] {
    PK_FILL,
    PK_PAD2,
    PK_LEN
  } pk_state_e;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha256_stream_hasher_unit.sv]
// Top level of the streaming SHA-256 hasher.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  message  | in  | push / full  | data_byte, byte_present, message_end
//  digest   | out | pop / empty  | digest_word, digest_last
//
// The packer writes each accepted byte into the current block. A full 64-byte
// block passes through the compression engine as a load, 64 rounds and one add,
// all done by the single shared round unit. The end of a message adds one or two
// padding blocks and then eight digest words, one per cycle while pop is high.
// Reset clears all control state and loads the initial hash values.
// A four-entry block queue lets the packer keep taking bytes while a block
// is being compressed; full rises when it nears capacity or during padding.
module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  // Block jobs travel from packer to engine through the packer's queue.
  logic          job_valid;
  logic          job_take;
  shs_pkg::job_t job;

  shs_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .message_end_i (message_end_i),
    .job_valid_o   (job_valid),
    .job_take_i    (job_take),
    .job_o         (job)
  );

  shs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_take_o   (job_take),
    .job_i        (job),
    .empty_o      (empty),
    .pop_i        (pop),
    .digest_word_o(digest_word_o),
    .digest_last_o(digest_last_o)
  );

endmodule

[rtl/shs_packer.sv]
// Front end: packs message bytes into blocks, pads, and queues block jobs.
module shs_packer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    data_byte_i,
  input  logic          byte_present_i,
  input  logic          message_end_i,
  output logic          job_valid_o,
  input  logic          job_take_i,
  output shs_pkg::job_t job_o
);

  logic [511:0]          blk_q, blk_d;
  logic [5:0]            fill_q, fill_d;
  logic [60:0]           total_q, total_d;
  shs_pkg::pk_state_e    st_q, st_d;
  shs_pkg::job_t         q_mem [shs_pkg::QDepth];
  logic [shs_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [shs_pkg::QPtrW:0]   cnt_q;
  logic                  enq;
  shs_pkg::job_t         enq_job;
  logic                  room;
  logic                  accept;
  logic [63:0]           bits;

  // Two slots of room keep the padding path simple.
  assign room   = (cnt_q <= (shs_pkg::QPtrW+1)'(shs_pkg::QDepth - 2));
  assign full_o = !(room && st_q == shs_pkg::PK_FILL);
  assign accept = push_i && !full_o;
  assign bits   = {total_q, 3'b000};

  always_comb begin
    blk_d   = blk_q;
    fill_d  = fill_q;
    total_d = total_q;
    st_d    = st_q;
    enq     = 1'b0;
    enq_job = '{block: blk_q, fin: 1'b0};
    unique case (st_q)
      shs_pkg::PK_FILL: begin
        if (accept) begin
          if (byte_present_i) begin
            blk_d[511 - 8*fill_q -: 8] = data_byte_i;
            total_d = total_q + 61'd1;
            fill_d  = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              enq     = 1'b1;
              enq_job = '{block: blk_d, fin: 1'b0};
            end
          end
          if (message_end_i) begin
            // Write the pad byte now from the updated fill; PAD2 or LEN then queues it.
            st_d = (fill_d >= 6'd56) ? shs_pkg::PK_PAD2 : shs_pkg::PK_LEN;
            if (!(byte_present_i && fill_q == 6'd63)) begin
              blk_d[511 - 8*fill_d -: 8] = shs_pkg::PadByte;
              for (int i = 0; i < 64; i++) begin
                if (6'(i) > fill_d) blk_d[511 - 8*i -: 8] = 8'h00;
              end
            end else begin
              blk_d = '0;
              blk_d[511 -: 8] = shs_pkg::PadByte;
            end
          end
        end
      end
      shs_pkg::PK_PAD2: begin
        enq     = 1'b1;
        enq_job = '{block: blk_q, fin: 1'b0};
        blk_d   = '0;
        st_d    = shs_pkg::PK_LEN;
      end
      default: begin
        enq     = 1'b1;
        enq_job = '{block: {blk_q[511:64], bits}, fin: 1'b1};
        blk_d   = '0;
        fill_d  = '0;
        total_d = '0;
        st_d    = shs_pkg::PK_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q   <= '0;
      fill_q  <= '0;
      total_q <= '0;
      st_q    <= shs_pkg::PK_FILL;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      blk_q   <= blk_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      st_q    <= st_d;
      if (enq) wr_q <= wr_q + 1'b1;
      if (job_take_i && job_valid_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (shs_pkg::QPtrW+1)'(enq)
             - (shs_pkg::QPtrW+1)'(job_take_i && job_valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_mem[wr_q] <= enq_job;
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_q];

  `include "sha256_stream_hasher_unit_macros.svh"
  `SHS_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, enq,
    cnt_q < (shs_pkg::QPtrW+1)'(shs_pkg::QDepth), "job queue overflow")
  `SHS_ASSERT_NEXT(a_pad_to_len, clk_i, rst_ni, st_q == shs_pkg::PK_PAD2,
    st_q == shs_pkg::PK_LEN, "second pad block not followed by length block")
  `SHS_ASSERT_IMPL(a_len_clears, clk_i, rst_ni, st_q == shs_pkg::PK_LEN,
    enq && enq_job.fin, "length block not queued as final")

endmodule

[rtl/shs_engine.sv]
// Back end: one SHA-256 round per cycle and digest word output register.
module shs_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_take_o,
  input  shs_pkg::job_t job_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [31:0]   digest_word_o,
  output logic          digest_last_o
);

  shs_pkg::eng_state_e st_q, st_d;
  shs_pkg::word_t h_q [8];
  shs_pkg::word_t v_q [8];
  shs_pkg::word_t w_q [16];
  logic [5:0]     rnd_q;
  logic           fin_q;
  logic [2:0]     oidx_q;
  logic           ovalid_q;
  logic           oload;
  shs_pkg::word_t wt, s0, s1, t1, t2, ch, mj, e1, a0;

  // Next schedule word: block words for the first 16 rounds, then expansion; also the round terms t1 and t2.
  always_comb begin
    s0 = shs_pkg::rotr(w_q[1], 7) ^ shs_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = shs_pkg::rotr(w_q[14], 17) ^ shs_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wt = (rnd_q < 6'd16) ? w_q[0] : (s1 + w_q[9] + s0 + w_q[0]);
    e1 = shs_pkg::rotr(v_q[4], 6) ^ shs_pkg::rotr(v_q[4], 11) ^ shs_pkg::rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    a0 = shs_pkg::rotr(v_q[0], 2) ^ shs_pkg::rotr(v_q[0], 13) ^ shs_pkg::rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + e1 + ch + shs_pkg::RoundK[rnd_q] + wt;
    t2 = a0 + mj;
  end

  assign oload = !ovalid_q || pop_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      shs_pkg::ENG_IDLE:  if (job_valid_i) st_d = shs_pkg::ENG_ROUND;
      shs_pkg::ENG_ROUND: if (rnd_q == 6'd63) st_d = shs_pkg::ENG_ADD;
      shs_pkg::ENG_ADD:   st_d = fin_q ? shs_pkg::ENG_OUT : shs_pkg::ENG_IDLE;
      default:            if (oload && oidx_q == 3'd7) st_d = shs_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    job_take_o = (st_q == shs_pkg::ENG_IDLE) && job_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= shs_pkg::ENG_IDLE;
      rnd_q    <= '0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
      fin_q    <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= shs_pkg::InitH[i];
    end else begin
      st_q <= st_d;
      if (job_take_o) begin
        fin_q <= job_i.fin;
        rnd_q <= '0;
      end
      if (st_q == shs_pkg::ENG_ROUND) rnd_q <= rnd_q + 6'd1;
      if (st_q == shs_pkg::ENG_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (st_q == shs_pkg::ENG_OUT && oload) begin
        ovalid_q <= 1'b1;
        oidx_q   <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= shs_pkg::InitH[i];
        end
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      for (int i = 0; i < 16; i++) w_q[i] <= job_i.block[511 - 32*i -: 32];
    end else if (st_q == shs_pkg::ENG_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (st_q == shs_pkg::ENG_OUT && oload) begin
      digest_word_o <= h_q[oidx_q];
      digest_last_o <= (oidx_q == 3'd7);
    end
  end

  assign empty_o = !ovalid_q;

  `include "sha256_stream_hasher_unit_macros.svh"
  `SHS_ASSERT_IMPL(a_take_idle, clk_i, rst_ni, job_take_o,
    st_q == shs_pkg::ENG_IDLE, "job taken while busy")
  `SHS_ASSERT_NEXT(a_round_end, clk_i, rst_ni,
    st_q == shs_pkg::ENG_ROUND && rnd_q == 6'd63, st_q == shs_pkg::ENG_ADD,
    "round counter did not end compression")
  `SHS_ASSERT_IMPL(a_out_phase, clk_i, rst_ni, st_q == shs_pkg::ENG_ROUND,
    oidx_q == 3'd0, "digest index moved during compression")

endmodule
